// File: hw/rtl/swc_pkg.sv
// Shared types, constants and element helpers for the sparse weight compactor.
`default_nettype none

package swc_pkg;

	// Alignment of a channel block in bytes (4 to 64).
	localparam int unsigned ALIGN_BYTES = 16;
	// Results one input may cause, element included.
	localparam int unsigned MAX_RESULTS = 16;
	// Entries in the command queue between front and back.
	localparam int unsigned QDEPTH      = 4;

	localparam int unsigned PHASE_W = $clog2(ALIGN_BYTES);
	localparam int unsigned SUM_W   = $clog2(ALIGN_BYTES + 4);
	localparam int unsigned NEED_W  = $clog2(ALIGN_BYTES + 3);
	localparam int unsigned CNT_W   = $clog2(MAX_RESULTS + 1);
	localparam int unsigned CMP_W   = (NEED_W > CNT_W) ? NEED_W : CNT_W;
	localparam int unsigned QA_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QC_W    = $clog2(QDEPTH + 1);
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned CIDX_W  = 1;

	// Element kinds.
	localparam logic [KIND_W-1:0] KIND_INT8  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_UINT8 = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FP16  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BF16  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FP32  = 3'd4;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_ELEMENT_KIND   = 1'd0;
	localparam logic [CIDX_W-1:0] REG_SPARSE_PATTERN = 1'd1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] pattern;
	} cfg_t;

	// One classified item: kept element and padding still to emit.
	typedef struct packed {
		logic [DATA_W-1:0] bits;
		logic              keep;
		logic              last;
		logic [CNT_W-1:0]  pad;
	} cmd_t;

	// Element size in bytes.
	function automatic logic [2:0] kind_bytes(input logic [KIND_W-1:0] k);
		logic [2:0] b;
		begin
			case (k)
				KIND_FP16, KIND_BF16: b = 3'd2;
				KIND_FP32:            b = 3'd4;
				default:              b = 3'd1;
			endcase
			return b;
		end
	endfunction

	// log2 of the element size.
	function automatic logic [1:0] kind_shift(input logic [KIND_W-1:0] k);
		logic [1:0] s;
		begin
			case (k)
				KIND_FP16, KIND_BF16: s = 2'd1;
				KIND_FP32:            s = 2'd2;
				default:              s = 2'd0;
			endcase
			return s;
		end
	endfunction

	function automatic logic [DATA_W-1:0] kind_mask(input logic [KIND_W-1:0] k);
		logic [DATA_W-1:0] m;
		begin
			case (k)
				KIND_FP16, KIND_BF16: m = 32'h0000_FFFF;
				KIND_FP32:            m = 32'hFFFF_FFFF;
				default:              m = 32'h0000_00FF;
			endcase
			return m;
		end
	endfunction

	// Match against the sparse value; v and s are already masked.
	// Float kinds: signed zeros match each other, NaN never matches.
	function automatic logic is_sparse(input logic [DATA_W-1:0] v,
	                                   input logic [DATA_W-1:0] s,
	                                   input logic [KIND_W-1:0] k);
		logic [DATA_W-1:0] mag;
		logic [DATA_W-1:0] expo;
		logic [DATA_W-1:0] mant;
		logic              isf;
		logic              a_nan;
		logic              b_nan;
		logic              a_z;
		logic              b_z;
		begin
			isf  = 1'b1;
			mag  = 32'h7FFF_FFFF;
			expo = 32'h7F80_0000;
			mant = 32'h007F_FFFF;
			case (k)
				KIND_FP16: begin
					mag  = 32'h0000_7FFF;
					expo = 32'h0000_7C00;
					mant = 32'h0000_03FF;
				end
				KIND_BF16: begin
					mag  = 32'h0000_7FFF;
					expo = 32'h0000_7F80;
					mant = 32'h0000_007F;
				end
				KIND_FP32: begin
					mag  = 32'h7FFF_FFFF;
					expo = 32'h7F80_0000;
					mant = 32'h007F_FFFF;
				end
				default: isf = 1'b0;
			endcase
			a_z   = (v & mag) == '0;
			b_z   = (s & mag) == '0;
			a_nan = ((v & expo) == expo) && ((v & mant) != '0);
			b_nan = ((s & expo) == expo) && ((s & mant) != '0);
			if (!isf)
				return v == s;
			return !(a_nan || b_nan) && ((a_z && b_z) || (v == s));
		end
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/swc_front.sv
// Front end: sparse test, byte phase tracking and padding count per item.
`default_nettype none

module swc_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire swc_pkg::cfg_t                 cfg,
	input  wire logic                          accept,
	input  wire logic [swc_pkg::DATA_W-1:0]    element_bits,
	input  wire logic                          channel_end,
	output swc_pkg::cmd_t                      cmd
);
	import swc_pkg::*;

	logic [PHASE_W-1:0] phase_q;
	logic [DATA_W-1:0]  mask;
	logic [DATA_W-1:0]  v;
	logic [DATA_W-1:0]  s;
	logic               keep;
	logic [2:0]         size;
	logic [SUM_W-1:0]   sum;
	logic [SUM_W-1:0]   kept_phase;
	logic [NEED_W-1:0]  need;
	logic [NEED_W-1:0]  cnt;
	logic [CMP_W-1:0]   cnt_x;
	logic [CMP_W-1:0]   limit_x;
	logic [CNT_W-1:0]   pad;

	assign mask = kind_mask(cfg.kind);
	assign v    = element_bits & mask;
	assign s    = cfg.pattern & mask;
	assign keep = !is_sparse(v, s, cfg.kind);
	assign size = kind_bytes(cfg.kind);

	always_comb begin
		sum        = SUM_W'(phase_q) + (keep ? SUM_W'(size) : '0);
		kept_phase = (sum >= SUM_W'(ALIGN_BYTES)) ? sum - SUM_W'(ALIGN_BYTES) : sum;
		need       = NEED_W'(ALIGN_BYTES) - NEED_W'(kept_phase) + NEED_W'(size) - NEED_W'(1);
		cnt        = (kept_phase == '0) ? '0 : (need >> kind_shift(cfg.kind));
		cnt_x      = CMP_W'(cnt);
		limit_x    = CMP_W'(MAX_RESULTS) - CMP_W'(keep);
		pad        = '0;
		if (channel_end)
			pad = (cnt_x > limit_x) ? CNT_W'(limit_x) : CNT_W'(cnt_x);
	end

	assign cmd.bits = v;
	assign cmd.keep = keep;
	assign cmd.last = channel_end;
	assign cmd.pad  = pad;

	// Phase restarts at a channel end, saturated padding or not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept) begin
			phase_q <= channel_end ? '0 : kept_phase[PHASE_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/swc_queue.sv
// Short command FIFO between front and back ends.
`default_nettype none

module swc_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire swc_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output swc_pkg::cmd_t      head,
	output logic               head_valid,
	output logic               full
);
	import swc_pkg::*;

	cmd_t             slot_q [QDEPTH];
	logic [QA_W-1:0]  wr_q;
	logic [QA_W-1:0]  rd_q;
	logic [QC_W-1:0]  count_q;

	assign head       = slot_q[rd_q];
	assign head_valid = count_q != '0;
	assign full       = count_q == QC_W'(QDEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QA_W'(QDEPTH - 1)) ? '0 : wr_q + QA_W'(1);
			if (pop)
				rd_q <= (rd_q == QA_W'(QDEPTH - 1)) ? '0 : rd_q + QA_W'(1);
			if (push && !pop)
				count_q <= count_q + QC_W'(1);
			else if (pop && !push)
				count_q <= count_q - QC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

// File: hw/rtl/swc_back.sv
// Back end: expands each command into element and padding results.
`default_nettype none

module swc_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire swc_pkg::cmd_t              head,
	input  wire logic                       head_valid,
	output logic                            pop,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [swc_pkg::DATA_W-1:0]      packed_bits,
	output logic                            is_padding,
	output logic                            run_last,
	output logic                            block_end
);
	import swc_pkg::*;

	logic              valid_q;
	logic [CNT_W-1:0]  rem_q;
	logic              last_q;
	logic              advance;
	logic              emit;
	logic              take;
	logic [CNT_W-1:0]  total;
	logic [CNT_W-1:0]  rem_d;
	logic              last_d;
	logic [DATA_W-1:0] bits_d;
	logic              pad_d;
	logic              rl_d;
	logic              be_d;

	assign advance = !valid_q || !out_stall;

	always_comb begin
		emit   = 1'b0;
		take   = 1'b0;
		total  = CNT_W'(head.keep) + head.pad;
		rem_d  = rem_q;
		last_d = last_q;
		bits_d = '0;
		pad_d  = 1'b1;
		rl_d   = 1'b0;
		be_d   = 1'b0;
		if (rem_q != '0) begin
			// padding left over from the current command
			emit  = 1'b1;
			rem_d = rem_q - CNT_W'(1);
			rl_d  = rem_q == CNT_W'(1);
			be_d  = rl_d && last_q;
		end else if (head_valid) begin
			take   = 1'b1;
			last_d = head.last;
			if (total != '0) begin
				emit   = 1'b1;
				bits_d = head.keep ? head.bits : '0;
				pad_d  = !head.keep;
				rem_d  = total - CNT_W'(1);
				rl_d   = rem_d == '0;
				be_d   = rl_d && head.last;
			end
		end
	end

	assign pop       = advance && take;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rem_q   <= '0;
			last_q  <= 1'b0;
		end else if (advance) begin
			valid_q <= emit;
			rem_q   <= rem_d;
			last_q  <= last_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			packed_bits <= bits_d;
			is_padding  <= pad_d;
			run_last    <= rl_d;
			block_end   <= be_d;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sparse_weight_compactor_top.sv
// Top level of the sparse weight compactor: config registers, front, queue, back.
`default_nettype none

//  channel  | signals                                     | direction
//  ---------+---------------------------------------------+----------
//  input    | in_valid, in_stall, element_bits,           | in
//           | channel_end                                 |
//  output   | out_valid, out_stall, packed_bits,          | out
//           | is_padding, run_last, block_end             |
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data   | in
//
//  An input transfer is classified in the cycle it arrives and lands in a
//  four-entry command queue; the back end emits one result per cycle from
//  it while out_stall is low, so a stream of kept elements runs at one
//  item per cycle. A channel end with padding yields up to 16 results; the
//  queue absorbs up to four items meanwhile before in_stall rises. The
//  queue slot and then the back end output register lie between input and
//  result. Reset clears the byte phase, queue, output valid and both config
//  registers; config writes are always taken (cfg_ready is tied high).
module sparse_weight_compactor_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [swc_pkg::DATA_W-1:0]     element_bits,
	input  wire logic                           channel_end,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [swc_pkg::DATA_W-1:0]          packed_bits,
	output logic                                is_padding,
	output logic                                run_last,
	output logic                                block_end,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [swc_pkg::CIDX_W-1:0]     cfg_index,
	input  wire logic [swc_pkg::DATA_W-1:0]     cfg_data
);
	import swc_pkg::*;

	cfg_t  cfg_q;
	cmd_t  front_cmd;
	cmd_t  head;
	logic  head_valid;
	logic  full;
	logic  accept;
	logic  pop;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign accept    = in_valid && !full;

	// Config writes must land only while idle; not enforced here. No shadowing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kind    <= KIND_INT8;
			cfg_q.pattern <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ELEMENT_KIND:   cfg_q.kind    <= cfg_data[KIND_W-1:0];
				REG_SPARSE_PATTERN: cfg_q.pattern <= cfg_data;
				default:            ;
			endcase
		end
	end

	swc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.accept       (accept),
		.element_bits (element_bits),
		.channel_end  (channel_end),
		.cmd          (front_cmd)
	);

	swc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_cmd   (front_cmd),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	swc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.packed_bits (packed_bits),
		.is_padding  (is_padding),
		.run_last    (run_last),
		.block_end   (block_end)
	);

endmodule

`default_nettype wire
